// File: hw/rtl/plid_pkg.sv
`timescale 1ns / 1ps

package plid_pkg;

   // default list depth
   localparam int CAPACITY_DEFAULT = 16;

   // fixed field widths
   localparam int KIND_W   = 1;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SHIFT  = 4'b0010,
      ST_PUT    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// File: hw/rtl/plid_ram.sv
`timescale 1ns / 1ps

module plid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in one RAM, empty
// after reset. An insert places value at the 1-based position and moves later
// entries back by one; a delete removes the entry at position, moves later
// entries forward and returns the removed value. Every item gives one result
// with the removed value (zero unless a delete succeeded), a status (done,
// list full, position out of range) and the new entry count; a failed item
// leaves the list untouched. Items are handled one at a time: a failed item
// goes straight to the finish step, while a successful one first moves the M
// entries that shift (length - position + 1 for insert, length - position for
// delete) and, for an insert, then writes the new value. Entries move one per
// cycle through the single read and write ports of the RAM. A new item can
// be accepted while the previous result still waits; a previous result held
// back by the receiver stalls the next item in its finish step until it is
// taken.

module positional_list_insert_delete #(
   parameter int CAPACITY = plid_pkg::CAPACITY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [plid_pkg::KIND_W-1:0]     req_kind,
   input  logic [plid_pkg::POS_W-1:0]      req_position,
   input  logic signed [plid_pkg::VALUE_W-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [plid_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [plid_pkg::STATUS_W-1:0]   rsp_status,
   output logic [plid_pkg::COUNT_W-1:0]    rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int PW = ((LW > plid_pkg::POS_W) ? LW : plid_pkg::POS_W) + 1;
   localparam int VW = plid_pkg::VALUE_W;

   plid_pkg::state_type state_ff, state_in;

   logic [LW-1:0]                   len_ff, len_in;
   logic [AW-1:0]                   cur_ff, cur_in;
   logic [AW-1:0]                   last_ff, last_in;
   logic [AW-1:0]                   wr_ff, wr_in;
   logic [AW-1:0]                   put_ff, put_in;
   logic [VW-1:0]                   val_ff, val_in;
   logic [VW-1:0]                   removed_ff, removed_in;
   logic [plid_pkg::STATUS_W-1:0]   stat_ff, stat_in;
   logic                            ins_ff, ins_in;
   logic                            more_ff, more_in;
   logic                            pend_ff, pend_in;
   logic                            first_ff, first_in;
   logic                            tag_ff, tag_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                   rsp_removed_ff, rsp_removed_in;
   logic [plid_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [plid_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                            ram_we, ram_re;
   logic [AW-1:0]                   ram_waddr, ram_raddr;
   logic [VW-1:0]                   ram_wdata, ram_rdata;

   logic [PW-1:0]                   len_x, pos_x, pos_m1, len_m1, len_new_x;
   logic                            ins_full, ins_bad, del_bad, accept, rsp_free;

   // list storage
   plid_ram #(
      .WIDTH(VW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // position checks against the current length
   always_comb begin
      len_x    = PW'(len_ff);
      pos_x    = PW'(req_position);
      pos_m1   = pos_x - PW'(1);
      len_m1   = len_x - PW'(1);
      ins_full = (len_x >= PW'(CAPACITY));
      ins_bad  = (pos_x == '0) || (pos_x > len_x + PW'(1));
      del_bad  = (pos_x == '0) || (pos_x > len_x);
   end

   assign req_ready = (state_ff == plid_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign len_new_x = PW'(len_ff);

   // sequencer: entries move one per cycle; insert walks down and writes one
   // place higher, delete walks up and writes one place lower, so a write never
   // hits an entry still to be read and no forwarding is needed
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      cur_in         = cur_ff;
      last_in        = last_ff;
      wr_in          = wr_ff;
      put_in         = put_ff;
      val_in         = val_ff;
      removed_in     = removed_ff;
      stat_in        = stat_ff;
      ins_in         = ins_ff;
      more_in        = more_ff;
      pend_in        = pend_ff;
      first_in       = first_ff;
      tag_in         = tag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      ram_we         = 1'b0;
      ram_waddr      = wr_ff;
      ram_wdata      = ram_rdata;
      ram_re         = 1'b0;
      ram_raddr      = cur_ff;

      case (state_ff)
         plid_pkg::ST_IDLE: begin
            if (accept) begin
               removed_in = '0;
               val_in     = req_value;
               pend_in    = 1'b0;
               if (req_kind == plid_pkg::KIND_INSERT) begin
                  if (ins_full) begin
                     stat_in  = plid_pkg::STATUS_FULL;
                     state_in = plid_pkg::ST_FINISH;
                  end else if (ins_bad) begin
                     stat_in  = plid_pkg::STATUS_RANGE;
                     state_in = plid_pkg::ST_FINISH;
                  end else begin
                     stat_in  = plid_pkg::STATUS_DONE;
                     ins_in   = 1'b1;
                     cur_in   = AW'(len_m1);
                     last_in  = AW'(pos_m1);
                     put_in   = AW'(pos_m1);
                     more_in  = (len_x != pos_m1);
                     tag_in   = 1'b0;
                     len_in   = len_ff + LW'(1);
                     state_in = plid_pkg::ST_SHIFT;
                  end
               end else begin
                  if (del_bad) begin
                     stat_in  = plid_pkg::STATUS_RANGE;
                     state_in = plid_pkg::ST_FINISH;
                  end else begin
                     stat_in  = plid_pkg::STATUS_DONE;
                     ins_in   = 1'b0;
                     cur_in   = AW'(pos_m1);
                     last_in  = AW'(len_m1);
                     more_in  = 1'b1;
                     tag_in   = 1'b1;
                     len_in   = len_ff - LW'(1);
                     state_in = plid_pkg::ST_SHIFT;
                  end
               end
            end
         end

         plid_pkg::ST_SHIFT: begin
            // data read last cycle: removed value or an entry to move
            if (pend_ff) begin
               if (first_ff) begin
                  removed_in = ram_rdata;
               end else begin
                  ram_we = 1'b1;
               end
            end
            // next read
            if (more_ff) begin
               ram_re   = 1'b1;
               wr_in    = ins_ff ? (cur_ff + AW'(1)) : (cur_ff - AW'(1));
               cur_in   = ins_ff ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));
               more_in  = (cur_ff != last_ff);
               pend_in  = 1'b1;
               first_in = tag_ff;
               tag_in   = 1'b0;
            end else begin
               pend_in  = 1'b0;
               state_in = ins_ff ? plid_pkg::ST_PUT : plid_pkg::ST_FINISH;
            end
         end

         plid_pkg::ST_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = put_ff;
            ram_wdata = val_ff;
            state_in  = plid_pkg::ST_FINISH;
         end

         plid_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = removed_ff;
               rsp_status_in  = stat_ff;
               rsp_count_in   = len_new_x[plid_pkg::COUNT_W-1:0];
               state_in       = plid_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = plid_pkg::ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plid_pkg::ST_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         more_ff      <= 1'b0;
         first_ff     <= 1'b0;
         tag_ff       <= 1'b0;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         more_ff      <= more_in;
         first_ff     <= first_in;
         tag_ff       <= tag_in;
         ins_ff       <= ins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      last_ff        <= last_in;
      wr_ff          <= wr_in;
      put_ff         <= put_in;
      val_ff         <= val_in;
      removed_ff     <= removed_in;
      stat_ff        <= stat_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

   // length never passes the capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CAPACITY))
      else $error("list length above capacity");

   // a read and a write in the same cycle never touch the same entry
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read and write hit the same entry");

   // the list storage is only written while an item is at work
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == plid_pkg::ST_SHIFT || state_ff == plid_pkg::ST_PUT))
      else $error("list written outside an item");

   // a read in flight is only seen while shifting
   a_pend_shift: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == plid_pkg::ST_SHIFT))
      else $error("read data pending outside shift");

   // a failed item leaves the length as it was
   a_fail_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plid_pkg::ST_FINISH && rsp_free && stat_ff != plid_pkg::STATUS_DONE)
      |=> (len_ff == $past(len_ff)))
      else $error("failed item changed the length");

endmodule
